>>> rtl/core/crs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crs_pkg
// Types and constants shared by the clip rectangle stack core and its parts.
// ----------------------------------------------------------------------------
package crs_pkg;

  localparam int COORD_W  = 16;
  localparam int MARGIN_W = 10;

  typedef enum logic [1:0] {
    FUNC_BEGIN = 2'd0,
    FUNC_PUSH  = 2'd1,
    FUNC_POP   = 2'd2,
    FUNC_QUERY = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCIS
  } state_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] w;
    logic signed [COORD_W-1:0] h;
  } rect_t;

  localparam int RECT_W = $bits(rect_t);

  typedef struct packed {
    logic [15:0] left;
    logic [14:0] top;
    logic [15:0] right;
    logic [15:0] bottom;
  } scis_t;

endpackage

>>> rtl/core/clip_rect_stack_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clip_rect_stack_core
// Stack of clip rectangles held in a RAM; begin, push, pop and query commands,
// each answered with the top entry and, where it changes, a screen scissor.
// ----------------------------------------------------------------------------
//  channel   handshake             payload
//  command   start / busy          func, rect_x, rect_y, rect_w, rect_h
//  result    done (one cycle)      status, scissor_*, clip_*, stack_depth
//  config    cfg_wr_en             cfg_wr_data (side margin)
//
// a command passes through stack RAM read, modify and write back, and scissor
// mapping; the result strobe follows in the next cycle, while the next command
// may already be accepted. the registered RAM read and the split of the intersect
// and scissor arithmetic set these steps.
// reset empties the stack and clears the margin; the RAM holds no reset value.
// results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module clip_rect_stack_core import crs_pkg::*; #(
  parameter int STACK_DEPTH    = 16,
  parameter int LOGICAL_WIDTH  = 320,
  parameter int LOGICAL_HEIGHT = 240,
  parameter int SCREEN_W       = 320,
  parameter int SCREEN_H       = 240,
  localparam int AW = $clog2(STACK_DEPTH),
  localparam int DW = $clog2(STACK_DEPTH + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                func,
  input  logic signed [COORD_W-1:0] rect_x,
  input  logic signed [COORD_W-1:0] rect_y,
  input  logic signed [COORD_W-1:0] rect_w,
  input  logic signed [COORD_W-1:0] rect_h,
  input  logic                      cfg_wr_en,
  input  logic [MARGIN_W-1:0]       cfg_wr_data,
  output logic                      done,
  output logic                      status,
  output logic                      scissor_emit,
  output logic [15:0]               scissor_left,
  output logic [14:0]               scissor_top,
  output logic [15:0]               scissor_right,
  output logic [15:0]               scissor_bottom,
  output logic                      clip_valid,
  output logic signed [COORD_W-1:0] clip_x,
  output logic signed [COORD_W-1:0] clip_y,
  output logic signed [COORD_W-1:0] clip_w,
  output logic signed [COORD_W-1:0] clip_h,
  output logic [DW-1:0]             stack_depth
);

  localparam logic [DW-1:0] DEPTH_FULL = DW'(STACK_DEPTH);
  localparam logic [DW-1:0] DEPTH_ONE  = DW'(1);
  localparam logic [DW-1:0] DEPTH_TWO  = DW'(2);

  state_t state, state_next;

  logic [MARGIN_W-1:0] margin;
  logic [DW-1:0]       depth;
  func_t               cmd;
  rect_t               in_rect;

  // result of the modify step
  rect_t ent;
  logic  ent_status;
  logic  ent_emit;
  logic  ent_valid;

  rect_t         ent_next;
  logic          status_next;
  logic          emit_next;
  logic [DW-1:0] depth_next;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  rect_t         ram_rdata;

  rect_t                     frame;
  rect_t                     isect;
  logic signed [COORD_W-1:0] i_left, i_top, i_right, i_bottom;
  logic signed [COORD_W-1:0] a_r, a_b, b_r, b_b;

  scis_t scis;

  logic accept;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  crs_ram #(
    .WIDTH(RECT_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ent_next),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  crs_scissor #(
    .SCREEN_W(SCREEN_W),
    .SCREEN_H(SCREEN_H)
  ) u_scis (
    .r      (ent),
    .margin (margin),
    .s      (scis)
  );

  // pop reads the entry that becomes the top, everything else the current top
  always_comb begin
    if (depth == '0) begin
      ram_raddr = '0;
    end else if (func_t'(func) == FUNC_POP && depth >= DEPTH_TWO) begin
      ram_raddr = AW'(depth - DEPTH_TWO);
    end else begin
      ram_raddr = AW'(depth - DEPTH_ONE);
    end
  end

  // full-frame rectangle and intersection with the top entry
  always_comb begin
    frame.x = 16'sd0 - {6'b0, margin};
    frame.y = '0;
    frame.w = 16'(LOGICAL_WIDTH) + {5'b0, margin, 1'b0};
    frame.h = 16'(LOGICAL_HEIGHT);

    a_r = ram_rdata.x + ram_rdata.w;
    a_b = ram_rdata.y + ram_rdata.h;
    b_r = in_rect.x + in_rect.w;
    b_b = in_rect.y + in_rect.h;
    i_left   = (ram_rdata.x > in_rect.x) ? ram_rdata.x : in_rect.x;
    i_top    = (ram_rdata.y > in_rect.y) ? ram_rdata.y : in_rect.y;
    i_right  = (a_r < b_r) ? a_r : b_r;
    i_bottom = (a_b < b_b) ? a_b : b_b;
    if (i_right <= i_left || i_bottom <= i_top) begin
      isect.x = in_rect.x;
      isect.y = in_rect.y;
      isect.w = 16'sd1;
      isect.h = 16'sd1;
    end else begin
      isect.x = i_left;
      isect.y = i_top;
      isect.w = i_right - i_left;
      isect.h = i_bottom - i_top;
    end
  end

  // modify step
  always_comb begin
    ent_next    = ram_rdata;
    status_next = 1'b0;
    emit_next   = 1'b0;
    depth_next  = depth;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    if (state == ST_EXEC) begin
      unique case (cmd)
        FUNC_BEGIN: begin
          ent_next   = frame;
          ram_we     = 1'b1;
          ram_waddr  = '0;
          depth_next = DEPTH_ONE;
          emit_next  = 1'b1;
        end
        FUNC_PUSH: begin
          if (depth == '0 || depth == DEPTH_FULL) begin
            status_next = 1'b1;
          end else begin
            ent_next   = isect;
            ram_we     = 1'b1;
            ram_waddr  = AW'(depth);
            depth_next = depth + DEPTH_ONE;
            emit_next  = 1'b1;
          end
        end
        FUNC_POP: begin
          if (depth <= DEPTH_ONE) begin
            status_next = 1'b1;
          end else begin
            depth_next = depth - DEPTH_ONE;
            emit_next  = 1'b1;
          end
        end
        FUNC_QUERY: begin
          status_next = (depth == '0);
        end
        default: begin
          status_next = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_SCIS;
      end
      ST_SCIS: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      depth  <= '0;
      margin <= '0;
      done   <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_SCIS);
      if (cfg_wr_en) begin
        margin <= cfg_wr_data;
      end
      if (state == ST_EXEC) begin
        depth <= depth_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd       <= func_t'(func);
      in_rect.x <= rect_x;
      in_rect.y <= rect_y;
      in_rect.w <= rect_w;
      in_rect.h <= rect_h;
    end
    if (state == ST_EXEC) begin
      ent        <= ent_next;
      ent_status <= status_next;
      ent_emit   <= emit_next;
      ent_valid  <= (depth_next != '0);
    end
    if (state == ST_SCIS) begin
      status         <= ent_status;
      scissor_emit   <= ent_emit;
      scissor_left   <= ent_emit ? scis.left   : '0;
      scissor_top    <= ent_emit ? scis.top    : '0;
      scissor_right  <= ent_emit ? scis.right  : '0;
      scissor_bottom <= ent_emit ? scis.bottom : '0;
      clip_valid     <= ent_valid;
      clip_x         <= ent_valid ? ent.x : '0;
      clip_y         <= ent_valid ? ent.y : '0;
      clip_w         <= ent_valid ? ent.w : '0;
      clip_h         <= ent_valid ? ent.h : '0;
      stack_depth    <= depth;
    end
  end

endmodule

>>> rtl/core/crs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crs_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module crs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/crs_scissor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crs_scissor
// Maps a logical clip rectangle to a clamped screen scissor rectangle.
// ----------------------------------------------------------------------------
module crs_scissor import crs_pkg::*; #(
  parameter int SCREEN_W = 320,
  parameter int SCREEN_H = 240
) (
  input  rect_t                r,
  input  logic [MARGIN_W-1:0]  margin,
  output scis_t                s
);

  localparam logic signed [17:0] SW = 18'(SCREEN_W);
  localparam logic signed [17:0] SH = 18'(SCREEN_H);

  logic signed [COORD_W-1:0] xr;
  logic signed [COORD_W-1:0] yb;
  logic signed [17:0] l, rt, t, b;
  logic signed [17:0] lc, rc, tc, bc;

  always_comb begin
    xr = r.x + r.w;
    yb = r.y + r.h;
    // screen x is logical x plus margin, no wrap
    l  = {{2{r.x[15]}}, r.x} + {8'b0, margin};
    rt = {{2{xr[15]}}, xr} + {8'b0, margin};
    t  = {{2{r.y[15]}}, r.y};
    b  = {{2{yb[15]}}, yb};

    lc = (l < 18'sd0) ? 18'sd0 : l;
    tc = (t < 18'sd0) ? 18'sd0 : t;
    rc = (rt > SW) ? SW : rt;
    bc = (b > SH) ? SH : b;
    if (rc <= lc) begin
      rc = lc + 18'sd1;
    end
    if (bc <= tc) begin
      bc = tc + 18'sd1;
    end

    s.left   = lc[15:0];
    s.top    = tc[14:0];
    s.right  = rc[15:0];
    s.bottom = bc[15:0];
  end

endmodule

>>> test/clip_rect_stack_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clip_rect_stack_core_tb
// Self-checking bench for the clip rectangle stack core. Commands go in over
// start/busy and every command beat is run through an in-bench model of the
// stack; each done strobe is checked field by field against the oldest
// predicted result. Directed cases for the empty, full and bottom-of-stack
// paths come first, then random command traffic under several side margins
// and sender idle rates.
// ----------------------------------------------------------------------------
module clip_rect_stack_core_tb;
  import crs_pkg::*;

  localparam int STACK_DEPTH    = 16;
  localparam int LOGICAL_WIDTH  = 320;
  localparam int LOGICAL_HEIGHT = 240;
  localparam int SCREEN_W       = 320;
  localparam int SCREEN_H       = 240;
  localparam int MARGIN_MAX     = (1 << MARGIN_W) - 1;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic        status;
    logic        emit;
    logic [15:0] left;
    logic [14:0] top;
    logic [15:0] right;
    logic [15:0] bottom;
    logic        valid;
    logic [15:0] cx;
    logic [15:0] cy;
    logic [15:0] cw;
    logic [15:0] ch;
    logic [4:0]  depth;
  } clip_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  func_t cmd_func = FUNC_QUERY;
  logic signed [COORD_W-1:0] cmd_x = '0;
  logic signed [COORD_W-1:0] cmd_y = '0;
  logic signed [COORD_W-1:0] cmd_w = '0;
  logic signed [COORD_W-1:0] cmd_h = '0;
  logic cfg_wr_en = 1'b0;
  logic [MARGIN_W-1:0] cfg_wr_data = '0;
  logic done;
  logic status;
  logic scissor_emit;
  logic [15:0] scissor_left;
  logic [14:0] scissor_top;
  logic [15:0] scissor_right;
  logic [15:0] scissor_bottom;
  logic clip_valid;
  logic signed [COORD_W-1:0] clip_x;
  logic signed [COORD_W-1:0] clip_y;
  logic signed [COORD_W-1:0] clip_w;
  logic signed [COORD_W-1:0] clip_h;
  logic [4:0] stack_depth;

  // model of the stack
  rect_t clip_model [STACK_DEPTH];
  int    depth_model = 0;
  int    margin_model = 0;

  clip_result_t expected_results [$];
  int sender_idle_pct = 0;
  int mismatches = 0;
  int results_checked = 0;
  int cmd_count [4] = '{0, 0, 0, 0};
  int margin_writes = 0;

  always #4 clk = ~clk;

  clip_rect_stack_core #(
    .STACK_DEPTH   (STACK_DEPTH),
    .LOGICAL_WIDTH (LOGICAL_WIDTH),
    .LOGICAL_HEIGHT(LOGICAL_HEIGHT),
    .SCREEN_W      (SCREEN_W),
    .SCREEN_H      (SCREEN_H)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .func          (cmd_func),
    .rect_x        (cmd_x),
    .rect_y        (cmd_y),
    .rect_w        (cmd_w),
    .rect_h        (cmd_h),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .done          (done),
    .status        (status),
    .scissor_emit  (scissor_emit),
    .scissor_left  (scissor_left),
    .scissor_top   (scissor_top),
    .scissor_right (scissor_right),
    .scissor_bottom(scissor_bottom),
    .clip_valid    (clip_valid),
    .clip_x        (clip_x),
    .clip_y        (clip_y),
    .clip_w        (clip_w),
    .clip_h        (clip_h),
    .stack_depth   (stack_depth)
  );

  function automatic int wrap16(int v);
    logic signed [15:0] t;
    t = v[15:0];
    return int'(t);
  endfunction

  function automatic clip_result_t add_scissor(rect_t r, clip_result_t res);
    int left, right, top, bottom;
    left   = int'(r.x) + margin_model;
    right  = wrap16(int'(r.x) + int'(r.w)) + margin_model;
    top    = int'(r.y);
    bottom = wrap16(int'(r.y) + int'(r.h));
    if (left < 0) left = 0;
    if (right > SCREEN_W) right = SCREEN_W;
    if (top < 0) top = 0;
    if (bottom > SCREEN_H) bottom = SCREEN_H;
    if (right <= left) right = left + 1;
    if (bottom <= top) bottom = top + 1;
    res.emit   = 1'b1;
    res.left   = left[15:0];
    res.top    = top[14:0];
    res.right  = right[15:0];
    res.bottom = bottom[15:0];
    return res;
  endfunction

  // advances the model by one command and returns the result it causes
  function automatic clip_result_t predict_clip_cmd(func_t f, rect_t b);
    clip_result_t res;
    rect_t a, c;
    int left, top, right, bottom, ar, br, ab, bb;
    res = '0;
    case (f)
      FUNC_BEGIN: begin
        c.x = 16'(wrap16(-margin_model));
        c.y = '0;
        c.w = 16'(wrap16(LOGICAL_WIDTH + 2 * margin_model));
        c.h = 16'(wrap16(LOGICAL_HEIGHT));
        clip_model[0] = c;
        depth_model = 1;
        res = add_scissor(c, res);
      end
      FUNC_PUSH: begin
        if (depth_model == 0 || depth_model >= STACK_DEPTH) begin
          res.status = 1'b1;
        end else begin
          a = clip_model[depth_model - 1];
          left   = (a.x > b.x) ? int'(a.x) : int'(b.x);
          top    = (a.y > b.y) ? int'(a.y) : int'(b.y);
          ar     = wrap16(int'(a.x) + int'(a.w));
          br     = wrap16(int'(b.x) + int'(b.w));
          ab     = wrap16(int'(a.y) + int'(a.h));
          bb     = wrap16(int'(b.y) + int'(b.h));
          right  = (ar < br) ? ar : br;
          bottom = (ab < bb) ? ab : bb;
          if (right <= left || bottom <= top) begin
            // empty intersection keeps the pushed origin at 1x1
            c.x = b.x;
            c.y = b.y;
            c.w = 16'sd1;
            c.h = 16'sd1;
          end else begin
            c.x = left[15:0];
            c.y = top[15:0];
            c.w = 16'(wrap16(right - left));
            c.h = 16'(wrap16(bottom - top));
          end
          clip_model[depth_model] = c;
          depth_model++;
          res = add_scissor(c, res);
        end
      end
      FUNC_POP: begin
        if (depth_model <= 1) begin
          res.status = 1'b1;
        end else begin
          depth_model--;
          res = add_scissor(clip_model[depth_model - 1], res);
        end
      end
      default: begin
        if (depth_model == 0) res.status = 1'b1;
      end
    endcase
    if (depth_model > 0) begin
      a = clip_model[depth_model - 1];
      res.valid = 1'b1;
      res.cx = a.x;
      res.cy = a.y;
      res.cw = a.w;
      res.ch = a.h;
    end
    res.depth = depth_model[4:0];
    return res;
  endfunction

  // one command beat; returns right after the accepting edge with start held
  task automatic send_cmd(func_t f, logic [15:0] x, logic [15:0] y,
                          logic [15:0] w, logic [15:0] h);
    rect_t b;
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start    <= 1'b1;
    cmd_func <= f;
    cmd_x    <= x;
    cmd_y    <= y;
    cmd_w    <= w;
    cmd_h    <= h;
    do @(posedge clk); while (busy);
    b.x = x;
    b.y = y;
    b.w = w;
    b.h = h;
    expected_results.push_back(predict_clip_cmd(f, b));
    cmd_count[f]++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_margin(int m);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m[MARGIN_W-1:0];
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    margin_model = m;
    margin_writes++;
  endtask

  function automatic logic [15:0] corner_value();
    case ($urandom_range(3))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      default: return 16'hFFFF;
    endcase
  endfunction

  // mostly coordinates around the frame, sometimes anything at all
  function automatic logic [15:0] rand_coord();
    int v;
    if ($urandom_range(3) == 0) return 16'($urandom);
    v = $urandom_range(1400) - 500;
    return v[15:0];
  endfunction

  function automatic logic [15:0] rand_size();
    if ($urandom_range(3) == 0) return 16'($urandom);
    return 16'($urandom_range(400));
  endfunction

  task automatic test_empty_stack();
    send_cmd(FUNC_QUERY, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_cmd(FUNC_PUSH, 16'h0010, 16'h0010, 16'h0020, 16'h0020);
    send_cmd(FUNC_POP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
  endtask

  // nested and corner-valued pushes until full, then one push too many
  task automatic test_stack_fill();
    int i;
    send_cmd(FUNC_BEGIN, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    for (i = 1; i < STACK_DEPTH; i++) begin
      if (i % 3 == 0)
        send_cmd(FUNC_PUSH, corner_value(), corner_value(), corner_value(), corner_value());
      else
        send_cmd(FUNC_PUSH, 16'(i * 4 - 20), 16'(i * 3 - 10), 16'(300 - 8 * i),
                 16'(220 - 6 * i));
    end
    send_cmd(FUNC_PUSH, 16'h0005, 16'h0005, 16'h0010, 16'h0010);
  endtask

  task automatic test_pop_to_bottom();
    send_cmd(FUNC_BEGIN, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
    send_cmd(FUNC_PUSH, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
    send_cmd(FUNC_QUERY, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_cmd(FUNC_POP, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_cmd(FUNC_POP, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
  endtask

  task automatic run_random_traffic(int n_items, int idle_pct, int first_margin,
                                    int last_margin);
    int seg, i, pick;
    func_t f;
    sender_idle_pct = idle_pct;
    for (seg = 0; seg < 3; seg++) begin
      set_margin(seg == 0 ? first_margin :
                 seg == 1 ? $urandom_range(1, MARGIN_MAX - 1) : last_margin);
      for (i = 0; i < n_items / 3; i++) begin
        pick = $urandom_range(99);
        if (depth_model == 0 && pick < 80) f = FUNC_BEGIN;
        else if (pick < 6) f = FUNC_BEGIN;
        else if (pick < 52) f = FUNC_PUSH;
        else if (pick < 85) f = FUNC_POP;
        else if (pick < 93) f = FUNC_QUERY;
        else f = func_t'($urandom_range(3));
        send_cmd(f, rand_coord(), rand_coord(), rand_size(), rand_size());
      end
    end
  endtask

  always @(posedge clk) begin
    clip_result_t got, want;
    if (!rst && done) begin
      got = {status, scissor_emit, scissor_left, scissor_top, scissor_right,
             scissor_bottom, clip_valid, clip_x, clip_y, clip_w, clip_h, stack_depth};
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] result beat with nothing expected: %p", $realtime, got);
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (got.status !== want.status || got.emit !== want.emit ||
            got.left !== want.left || got.top !== want.top ||
            got.right !== want.right || got.bottom !== want.bottom ||
            got.valid !== want.valid || got.cx !== want.cx || got.cy !== want.cy ||
            got.cw !== want.cw || got.ch !== want.ch || got.depth !== want.depth) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("[%0t] mismatch on result %0d", $realtime, results_checked);
            $display("  expected %p", want);
            $display("  actual   %p", got);
          end
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    sender_idle_pct = 23;
    test_empty_stack();
    test_stack_fill();
    test_pop_to_bottom();

    run_random_traffic(366, 23, 0, MARGIN_MAX);
    run_random_traffic(366, 72, MARGIN_MAX, 0);
    run_random_traffic(366, 0, 512, MARGIN_MAX);

    wait_drained();
    repeat (10) @(posedge clk);
    $display("ran %0d begin, %0d push, %0d pop, %0d query commands; %0d results checked",
             cmd_count[FUNC_BEGIN], cmd_count[FUNC_PUSH], cmd_count[FUNC_POP],
             cmd_count[FUNC_QUERY], results_checked);
    $display("%0d side margin writes across three sender idle rates, %0d mismatches",
             margin_writes, mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("timeout waiting for results");
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> files.f
rtl/core/crs_pkg.sv
rtl/core/crs_ram.sv
rtl/core/crs_scissor.sv
rtl/core/clip_rect_stack_core.sv
test/clip_rect_stack_core_tb.sv
